FILE: design/binary_search_with_halving_count_assert.svh
// Assertion macros shared by the search block.
// Each property is sampled on the rising edge of clk_i and is disabled during reset.
`ifndef BINARY_SEARCH_WITH_HALVING_COUNT_ASSERT_SVH
`define BINARY_SEARCH_WITH_HALVING_COUNT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check that a condition holds at every edge.
`define BSWHC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bswhc assertion failed");

// Check that a trigger implies a consequence on the next edge.
`define BSWHC_ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error("bswhc assertion failed");

`else

`define BSWHC_ASSERT(label, prop)
`define BSWHC_ASSERT_NEXT(label, trig, cons)

`endif

`endif

FILE: design/bswhc_pkg.sv
`timescale 1ns / 1ps
package bswhc_pkg;

  // Default sizes.
  localparam int StoreDepth = 128;
  localparam int QueueDepth = 4;

  // Field widths.
  localparam int CountW    = 8;
  localparam int IndexW    = 7;
  localparam int DataW     = 32;
  localparam int PositionW = 7;
  localparam int HalvingsW = 4;

  // Request operation codes.
  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } op_e;

  // Classified request, as held in the queue.
  typedef struct packed {
    op_e                      op;
    logic                     wr_ok;  // write index lies inside the store
    logic [IndexW-1:0]        widx;
    logic signed [DataW-1:0]  data;   // element value or search key
  } cmd_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

FILE: design/binary_search_with_halving_count.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                  Payload
// request   in         in_valid_i / in_stall_o    operation_i, write_index_i,
//                                                 element_value_i, search_key_i
// result    out        out_valid_o / out_stall_i  found_o, position_o, halvings_o
// config    in         cfg_valid_i / cfg_ready_o  cfg_data_i (element count)
//
// A write request is done in the back end as it leaves the queue; a search loads
// its bounds and then makes 1 .. floor(log2(count)) + 1 probes, each a registered
// read of the single-port store. On an empty store the search skips the probes:
// it goes to the done state, then to the result register once that is free.
// Reset clears the queue, engine state, result valid flag and element count;
// the store contents stay undefined until written.
// A stalled result holds an ended search; the queue takes requests until full.
module binary_search_with_halving_count #(
  parameter int STORE_DEPTH = bswhc_pkg::StoreDepth,
  parameter int QUEUE_DEPTH = bswhc_pkg::QueueDepth
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // request channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  operation_i,
  input  logic [bswhc_pkg::IndexW-1:0]          write_index_i,
  input  logic signed [bswhc_pkg::DataW-1:0]    element_value_i,
  input  logic signed [bswhc_pkg::DataW-1:0]    search_key_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  found_o,
  output logic [bswhc_pkg::PositionW-1:0]       position_o,
  output logic [bswhc_pkg::HalvingsW-1:0]       halvings_o,
  // configuration channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [bswhc_pkg::CountW-1:0]          cfg_data_i
);

  localparam int BndW = $clog2(STORE_DEPTH + 1);

  logic [BndW-1:0]   count_q, count_d;
  logic              push;
  logic              pop;
  bswhc_pkg::cmd_t   push_cmd;
  bswhc_pkg::cmd_t   head_cmd;
  bswhc_pkg::qstat_t qstat;

  // Config is always taken; clamp the count to the store depth.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    count_d = count_q;
    if (cfg_valid_i) begin
      if (32'(cfg_data_i) > 32'(STORE_DEPTH)) begin
        count_d = BndW'(STORE_DEPTH);
      end else begin
        count_d = BndW'(cfg_data_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Front: accept and classify requests, push them into the queue.
  bswhc_front #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .write_index_i   (write_index_i),
    .element_value_i (element_value_i),
    .search_key_i    (search_key_i),
    .qstat_i         (qstat),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  // Queue: decouple the accept side from the search engine.
  bswhc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .pop_data_o  (head_cmd),
    .stat_o      (qstat)
  );

  // Back: store writes and the probe loop, with the result register.
  bswhc_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .count_i     (count_q),
    .qstat_i     (qstat),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .found_o     (found_o),
    .position_o  (position_o),
    .halvings_o  (halvings_o)
  );

endmodule

FILE: design/bswhc_front.sv
`timescale 1ns / 1ps
module bswhc_front #(
  parameter int STORE_DEPTH = bswhc_pkg::StoreDepth
) (
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  operation_i,
  input  logic [bswhc_pkg::IndexW-1:0]          write_index_i,
  input  logic signed [bswhc_pkg::DataW-1:0]    element_value_i,
  input  logic signed [bswhc_pkg::DataW-1:0]    search_key_i,
  input  bswhc_pkg::qstat_t                     qstat_i,
  output logic                                  push_o,
  output bswhc_pkg::cmd_t                       cmd_o
);

  bswhc_pkg::op_e op;

  assign op         = bswhc_pkg::op_e'(operation_i);
  assign in_stall_o = qstat_i.full;
  assign push_o     = in_valid_i && !qstat_i.full;

  // Classify: flag writes outside the store, keep only the data word the operation uses.
  always_comb begin
    cmd_o.op    = op;
    cmd_o.widx  = write_index_i;
    cmd_o.wr_ok = (32'(write_index_i) < 32'(STORE_DEPTH));
    unique case (op)
      bswhc_pkg::OP_WRITE:  cmd_o.data = element_value_i;
      bswhc_pkg::OP_SEARCH: cmd_o.data = search_key_i;
      default:              cmd_o.data = search_key_i;
    endcase
  end

endmodule

FILE: design/bswhc_queue.sv
`timescale 1ns / 1ps
`include "binary_search_with_halving_count_assert.svh"
module bswhc_queue #(
  parameter int DEPTH = bswhc_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bswhc_pkg::cmd_t   push_data_i,
  input  logic              pop_i,
  output bswhc_pkg::cmd_t   pop_data_o,
  output bswhc_pkg::qstat_t stat_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  bswhc_pkg::cmd_t slot_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == CntW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign pop_data_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  `BSWHC_ASSERT(a_no_push_full, !(push_i && stat_o.full))
  `BSWHC_ASSERT(a_no_pop_empty, !(pop_i && stat_o.empty))
  `BSWHC_ASSERT(a_cnt_bound, cnt_q <= CntW'(DEPTH))

endmodule

FILE: design/bswhc_back.sv
`timescale 1ns / 1ps
`include "binary_search_with_halving_count_assert.svh"
module bswhc_back #(
  parameter int STORE_DEPTH = bswhc_pkg::StoreDepth
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [$clog2(STORE_DEPTH + 1)-1:0]     count_i,
  input  bswhc_pkg::qstat_t                      qstat_i,
  input  bswhc_pkg::cmd_t                        cmd_i,
  output logic                                   pop_o,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   found_o,
  output logic [bswhc_pkg::PositionW-1:0]        position_o,
  output logic [bswhc_pkg::HalvingsW-1:0]        halvings_o
);

  localparam int IdxW  = $clog2(STORE_DEPTH);
  localparam int BndW  = $clog2(STORE_DEPTH + 1);
  localparam int HalvW = $clog2(IdxW + 2);
  localparam int WxW   = (IdxW > bswhc_pkg::IndexW) ? IdxW : bswhc_pkg::IndexW;
  localparam int PxW   = (IdxW > bswhc_pkg::PositionW) ? IdxW : bswhc_pkg::PositionW;
  localparam int HxW   = (HalvW > bswhc_pkg::HalvingsW) ? HalvW : bswhc_pkg::HalvingsW;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_PROBE = 3'b010,
    ST_DONE  = 3'b100
  } state_e;

  state_e                          state_q, state_d;
  logic [BndW-1:0]                 lo_q, lo_d;
  logic [BndW-1:0]                 hi_q, hi_d;      // exclusive upper bound
  logic [IdxW-1:0]                 mid_q, mid_d;
  logic [HalvW-1:0]                halv_q, halv_d;
  logic                            hit_q, hit_d;
  logic signed [bswhc_pkg::DataW-1:0] key_q, key_d;
  logic signed [bswhc_pkg::DataW-1:0] rd_q;
  logic signed [bswhc_pkg::DataW-1:0] store_mem [STORE_DEPTH];

  logic [BndW:0]                   mid_sum;
  logic [IdxW-1:0]                 mid_nxt;
  logic [WxW-1:0]                  widx_ext;
  logic                            mem_we;
  logic                            slot_free;
  logic                            load;

  logic                            res_valid_q;
  logic                            res_found_q;
  logic [IdxW-1:0]                 res_pos_q;
  logic [HalvW-1:0]                res_halv_q;
  logic [PxW-1:0]                  pos_ext;
  logic [HxW-1:0]                  halv_ext;

  assign slot_free = !res_valid_q || !out_stall_i;
  assign widx_ext  = WxW'(cmd_i.widx);

  // Midpoint of the next interval; it also addresses the store read.
  assign mid_sum = {1'b0, lo_d} + {1'b0, hi_d} - (BndW + 1)'(1);
  assign mid_nxt = IdxW'(mid_sum[BndW:1]);

  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    halv_d  = halv_q;
    hit_d   = hit_q;
    key_d   = key_q;
    pop_o   = 1'b0;
    mem_we  = 1'b0;
    load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!qstat_i.empty) begin
          pop_o = 1'b1;
          if (cmd_i.op == bswhc_pkg::OP_WRITE) begin
            mem_we = cmd_i.wr_ok;
          end else begin
            key_d  = cmd_i.data;
            lo_d   = '0;
            hi_d   = count_i;
            halv_d = '0;
            hit_d  = 1'b0;
            if (count_i == '0) begin
              mid_d   = '0;
              state_d = ST_DONE;
            end else begin
              mid_d   = mid_nxt;
              state_d = ST_PROBE;
            end
          end
        end
      end
      ST_PROBE: begin
        if (rd_q == key_q) begin
          hit_d = 1'b1;
          load  = slot_free;
        end else begin
          halv_d = halv_q + HalvW'(1);
          if (rd_q > key_q) begin
            hi_d = BndW'(mid_q);
          end else begin
            lo_d = BndW'(mid_q) + BndW'(1);
          end
          if (lo_d >= hi_d) begin
            mid_d = '0;
            load  = slot_free;
          end else begin
            mid_d = mid_nxt;
          end
        end
        if (hit_d || (lo_d >= hi_d)) begin
          state_d = load ? ST_IDLE : ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        res_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    halv_q <= halv_d;
    hit_q  <= hit_d;
    key_q  <= key_d;
    if (load) begin
      res_found_q <= hit_d;
      res_pos_q   <= mid_d;
      res_halv_q  <= halv_d;
    end
  end

  // Single-port store: one write or one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[widx_ext[IdxW-1:0]] <= cmd_i.data;
    end else begin
      rd_q <= store_mem[mid_d];
    end
  end

  assign pos_ext     = PxW'(res_pos_q);
  assign halv_ext    = HxW'(res_halv_q);
  assign out_valid_o = res_valid_q;
  assign found_o     = res_found_q;
  assign position_o  = pos_ext[bswhc_pkg::PositionW-1:0];
  assign halvings_o  = halv_ext[bswhc_pkg::HalvingsW-1:0];

  `BSWHC_ASSERT(a_probe_bounds, (state_q != ST_PROBE) || (lo_q < hi_q))
  `BSWHC_ASSERT(a_halv_bound, (state_q != ST_PROBE) || (halv_q <= HalvW'(IdxW + 1)))
  `BSWHC_ASSERT(a_load_free, !load || slot_free)
  `BSWHC_ASSERT_NEXT(a_done_held, (state_q == ST_DONE) && !slot_free, state_q == ST_DONE)

endmodule

FILE: sim/binary_search_with_halving_count_tb.sv
`timescale 1ns / 1ps
module binary_search_with_halving_count_tb;
  import bswhc_pkg::*;

  // Run shape.
  localparam int RANDOM_REQUESTS = 950;
  localparam int SETTLE_CYCLES   = 40;        // queue of writes plus one full search
  localparam longint TIMEOUT_NS  = 20000000;  // far past the slowest run
  localparam logic signed [DataW-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [DataW-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic                 found;
    logic [PositionW-1:0] position;
    logic [HalvingsW-1:0] halvings;
  } result_t;

  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    op_e                     op;
    logic [CountW-1:0]       count;
    logic [IndexW-1:0]       widx;
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] key;
    logic                    typed;   // result typed in by hand
    result_t                 want;
  } plan_row_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;
  typedef enum logic [1:0] {FILL_UNSORTED, FILL_SPREAD, FILL_CLUSTER} fill_mode_e;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic                    operation_i;
  logic [IndexW-1:0]       write_index_i;
  logic signed [DataW-1:0] element_value_i;
  logic signed [DataW-1:0] search_key_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic                    found_o;
  logic [PositionW-1:0]    position_o;
  logic [HalvingsW-1:0]    halvings_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CountW-1:0]       cfg_data_i;

  // Shadow of the block: store contents, live element count, results in flight.
  logic signed [DataW-1:0] store_model [StoreDepth];
  logic [CountW-1:0]       live_count;
  result_t                 pending_results [$];
  plan_row_t               plan [$];
  logic signed [DataW-1:0] fill_values [StoreDepth];

  int requests_sent;
  int searches_sent;
  int results_checked;
  int count_writes;
  int mismatches;
  int burst_left;
  bit pacing_on;

  binary_search_with_halving_count dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .write_index_i   (write_index_i),
    .element_value_i (element_value_i),
    .search_key_i    (search_key_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .found_o         (found_o),
    .position_o      (position_o),
    .halvings_o      (halvings_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  // 20 ns clock.
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Classic binary search over the live part of the store; count every missed probe.
  function automatic result_t search_store(input logic signed [DataW-1:0] key);
    result_t r;
    int      lo;
    int      hi;
    int      mid;
    bit      done;
    r    = '0;
    lo   = 0;
    hi   = int'(live_count) - 1;
    done = 1'b0;
    while (!done && lo <= hi) begin
      mid = (lo + hi) >> 1;
      if (store_model[mid] == key) begin
        r.found    = 1'b1;
        r.position = mid[PositionW-1:0];
        done       = 1'b1;
      end else begin
        r.halvings = r.halvings + 1'b1;
        // Step past mid toward the key.
        if (store_model[mid] > key) hi = mid - 1;
        else lo = mid + 1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // When pacing is on, drop valid for a random gap once the current burst is used up.
  task automatic pace_sender();
    int gap;
    if (pacing_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        gap        = $urandom_range(1, 8);
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  // Offer one request at a falling edge and hold it until accepted; record what it implies.
  task automatic send_request(input op_e op, input logic [IndexW-1:0] idx,
                              input logic signed [DataW-1:0] value,
                              input logic signed [DataW-1:0] key,
                              input bit typed, input result_t want);
    result_t exp_res;
    operation_i     = op;
    write_index_i   = idx;
    element_value_i = value;
    search_key_i    = key;
    in_valid_i      = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    requests_sent++;
    if (op == OP_SEARCH) begin
      searches_sent++;
      exp_res         = typed ? want : search_store(key);
      pending_results = {pending_results, exp_res};
    end else if (int'(idx) < StoreDepth) begin
      store_model[idx] = value;
    end
    @(negedge clk_i);
    pace_sender();
  endtask

  // Hold off the sender until every search result is back; optionally let writes drain too.
  task automatic drain_results(input bit settle);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    if (settle) repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write the element count; the block saturates it at the store depth.
  task automatic write_count(input logic [CountW-1:0] value);
    cfg_data_i  = value;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    live_count = (int'(value) > StoreDepth) ? CountW'(StoreDepth) : value;
    count_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic add_cfg(input logic [CountW-1:0] value);
    plan_row_t row;
    row  = '{ROW_CFG, OP_WRITE, value, '0, '0, '0, 1'b0, '0};
    plan = {plan, row};
  endtask

  task automatic add_req(input op_e op, input logic [IndexW-1:0] idx,
                         input logic signed [DataW-1:0] value,
                         input logic signed [DataW-1:0] key);
    plan_row_t row;
    row  = '{ROW_REQ, op, '0, idx, value, key, 1'b0, '0};
    plan = {plan, row};
  endtask

  task automatic add_check(input logic signed [DataW-1:0] key, input logic found,
                           input logic [PositionW-1:0] position,
                           input logic [HalvingsW-1:0] halvings);
    plan_row_t row;
    row  = '{ROW_REQ, OP_SEARCH, '0, '0, '0, key, 1'b1, '{found, position, halvings}};
    plan = {plan, row};
  endtask

  // Result side: check each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no search outstanding");
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        results_checked++;
        if (found_o !== want.found)
          report_mismatch($sformatf("found %b, want %b", found_o, want.found));
        if (position_o !== want.position)
          report_mismatch($sformatf("position %0d, want %0d", position_o, want.position));
        if (halvings_o !== want.halvings)
          report_mismatch($sformatf("halvings %0d, want %0d", halvings_o, want.halvings));
      end
    end
  end

  // Receiver: switch between stall patterns over random stretches, quiet stretches included.
  initial begin : result_stall
    stall_mode_e mode;
    int          stretch;
    int          tick;
    out_stall_i = 1'b0;
    tick        = 0;
    forever begin
      mode    = stall_mode_e'($urandom_range(0, 3));
      stretch = $urandom_range(32, 256);
      repeat (stretch) begin
        @(negedge clk_i);
        tick++;
        case (mode)
          STALL_NONE:     out_stall_i = 1'b0;
          STALL_LIGHT:    out_stall_i = ($urandom_range(0, 3) == 0);
          STALL_PERIODIC: out_stall_i = ((tick % 5) < 2);
          default:        out_stall_i = ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  // Hard limit on the whole run.
  initial begin
    #(TIMEOUT_NS);
    $display("tb: timeout with %0d results outstanding", pending_results.size());
    $display("tb: failure");
    $finish;
  end

  // Sender and configuration.
  initial begin : stimulus
    int          directed_sent;
    int          pick;
    int          n;
    int          k;
    int          idx;
    int          searches;
    int          acc;
    longint      seg;
    longint      tmp;
    bit          descending;
    fill_mode_e  fill;
    logic [CountW-1:0]       count_pick;
    logic signed [DataW-1:0] key;

    // Hold every input at a known value while reset is low.
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    operation_i     = OP_WRITE;
    write_index_i   = '0;
    element_value_i = '0;
    search_key_i    = '0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    live_count      = '0;
    requests_sent   = 0;
    searches_sent   = 0;
    results_checked = 0;
    count_writes    = 0;
    mismatches      = 0;
    burst_left      = 1;
    pacing_on       = 1'b1;
    for (k = 0; k < StoreDepth; k++) store_model[k] = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table. Count is zero out of reset, so early searches miss at once.
    add_check(32'sd0, 1'b0, '0, '0);
    add_check(VALUE_MIN, 1'b0, '0, '0);
    add_check(VALUE_MAX, 1'b0, '0, '0);
    add_req(OP_WRITE, 7'd0, VALUE_MIN, '0);
    add_req(OP_WRITE, 7'd1, -32'sd5, '0);
    add_req(OP_WRITE, 7'd2, 32'sd7, '0);
    add_req(OP_WRITE, 7'd3, VALUE_MAX, '0);
    add_req(OP_WRITE, 7'd127, 32'shA5A5_5A5A, '0);
    // Empty store written explicitly: still a miss with no halvings.
    add_cfg(8'd0);
    add_check(32'sd7, 1'b0, '0, '0);
    // Four sorted elements spanning the full signed range.
    add_cfg(8'd4);
    add_req(OP_SEARCH, '0, '0, VALUE_MIN);
    add_req(OP_SEARCH, '0, '0, VALUE_MAX);
    add_req(OP_SEARCH, '0, '0, 32'sd7);
    add_req(OP_SEARCH, '0, '0, -32'sd5);
    add_req(OP_SEARCH, '0, '0, 32'sd0);
    add_req(OP_SEARCH, '0, '0, -32'sd6);
    add_req(OP_SEARCH, '0, '0, 32'sh7FFF_FFFE);
    // Single element: hit on the first probe, or one halving and a miss.
    add_cfg(8'd1);
    add_check(VALUE_MIN, 1'b1, '0, 4'd0);
    add_check(VALUE_MAX, 1'b0, '0, 4'd1);
    // Break the ordering: the search follows the same comparisons, so 7 misses while 100 is still found.
    add_req(OP_WRITE, 7'd1, 32'sd100, '0);
    add_cfg(8'd3);
    add_req(OP_SEARCH, '0, '0, 32'sd7);
    add_req(OP_SEARCH, '0, '0, 32'sd100);

    for (k = 0; k < plan.size(); k++) begin
      if (plan[k].kind == ROW_CFG) begin
        drain_results(1'b1);
        write_count(plan[k].count);
      end else begin
        send_request(plan[k].op, plan[k].widx, plan[k].value, plan[k].key,
                     plan[k].typed, plan[k].want);
      end
    end
    directed_sent = requests_sent;

    // Random phases: set a count, load that many elements, then search them.
    while (requests_sent < directed_sent + RANDOM_REQUESTS) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) count_pick = 8'd0;
      else if (pick < 16) count_pick = 8'd128;
      else if (pick < 19) count_pick = 8'd255;
      else if (pick < 24) count_pick = CountW'($urandom_range(129, 254));
      else if (pick < 36) count_pick = CountW'($urandom_range(17, 127));
      else count_pick = CountW'($urandom_range(1, 16));
      n = (int'(count_pick) > StoreDepth) ? StoreDepth : int'(count_pick);
      pacing_on = ($urandom_range(0, 3) != 0);

      // Change the count only with the block idle.
      drain_results(1'b1);
      write_count(count_pick);

      pick = $urandom_range(0, 9);
      if (pick == 0) fill = FILL_UNSORTED;
      else if (pick < 5) fill = FILL_SPREAD;
      else fill = FILL_CLUSTER;

      if (n > 0) begin
        seg = 64'd4294967296 / n;
        acc = int'($urandom_range(0, 40)) - 20;
        for (k = 0; k < n; k++) begin
          case (fill)
            FILL_UNSORTED: fill_values[k] = $urandom;
            FILL_SPREAD: begin
              // One random value per equal slice of the signed range keeps order.
              tmp = -64'sd2147483648 + k * seg + (longint'($urandom) % seg);
              fill_values[k] = tmp[DataW-1:0];
            end
            default: begin
              // Tight cluster with repeats so keys hit often.
              fill_values[k] = acc;
              acc = acc + int'($urandom_range(0, 3));
            end
          endcase
        end
        if (fill == FILL_SPREAD && $urandom_range(0, 2) == 0) begin
          fill_values[0]   = VALUE_MIN;
          fill_values[n-1] = VALUE_MAX;
        end
      end

      // Load every live position, in either order.
      descending = ($urandom_range(0, 1) != 0);
      for (k = 0; k < n; k++) begin
        idx = descending ? (n - 1 - k) : k;
        send_request(OP_WRITE, idx[IndexW-1:0], fill_values[idx], $urandom, 1'b0, '0);
      end
      // Scribble above the live part now and then; it must not matter.
      if (n < StoreDepth && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3))
          send_request(OP_WRITE, IndexW'($urandom_range(n, StoreDepth - 1)), $urandom,
                       $urandom, 1'b0, '0);

      searches = $urandom_range(4, 40);
      repeat (searches) begin
        pick = $urandom_range(0, 99);
        if (pick < 6 && n < StoreDepth) begin
          send_request(OP_WRITE, IndexW'($urandom_range(n, StoreDepth - 1)), $urandom,
                       $urandom, 1'b0, '0);
        end else begin
          if (n == 0 || pick >= 92) begin
            key = $urandom;
          end else if (pick >= 88) begin
            key = $urandom_range(0, 1) ? VALUE_MIN : VALUE_MAX;
          end else begin
            // Mostly stored keys; nudge some by one to land between elements.
            key = store_model[$urandom_range(0, n - 1)];
            if (pick >= 70) key = pick[0] ? key + 1 : key - 1;
          end
          send_request(OP_SEARCH, IndexW'($urandom_range(0, StoreDepth - 1)), $urandom,
                       key, 1'b0, '0);
        end
        // Pause the sender until the block has answered every search.
        if ($urandom_range(0, 39) == 0) drain_results(1'b0);
      end
    end

    // Wait out the tail, then settle.
    drain_results(1'b1);
    $display("tb: %0d requests sent, %0d of them searches, %0d results checked",
             requests_sent, searches_sent, results_checked);
    $display("tb: %0d element count settings, %0d mismatches", count_writes, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
